FILE: sv/srdp_pkg.sv
// ----------------------------------------------------------------------------
// srdp_pkg
// Shared constants, types and helpers of the sparse row dot product block.
// ----------------------------------------------------------------------------
`default_nettype none

package srdp_pkg;

    // Store and row counter geometry
    localparam int VECTOR_DEPTH = 4096;
    localparam int MAX_ROWS     = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
    localparam int CNT_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 10;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_W  = 16;
    localparam int EXT_W   = SUM_W + 2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TERM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMPTY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    // Controls from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic mul_en;  // capture coefficient times entry
        logic acc_en;  // fold the product into the row sum
        logic negate;  // subtract instead of add
        logic clear;   // drop the row sum (wins over acc_en)
    } t_mac_ctrl;

    // Low bits of the row counter as the reported row number
    function automatic logic [ROW_W-1:0] row_out(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+ROW_W-1:0] wide;
        wide = {{ROW_W{1'b0}}, cnt};
        return wide[ROW_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/sparse_row_dot_product.sv
// ----------------------------------------------------------------------------
// sparse_row_dot_product
// Streams a sparse operator row by row against a vector held in a local
// store, giving one saturated Q32.16 sum per row.
// ----------------------------------------------------------------------------
// Results: a last term shows its row sum after the store read, the product
// register and the result register; an empty-row item shows its zero
// result in the cycle after its transfer. Terms go singly (store read,
// multiply, accumulate); loads, empty rows, restarts go each idle cycle.
// Reset: synchronous, active low; clears row sum, row counter and strobe.
// The vector store is not cleared. Results cannot be stalled.
`default_nettype none

module sparse_row_dot_product (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [srdp_pkg::MODE_W-1:0]  i_mode,
    input  wire logic        [srdp_pkg::INDEX_W-1:0] i_index,
    input  wire logic signed [srdp_pkg::VALUE_W-1:0] i_value,
    input  wire logic                                i_row_negate,
    input  wire logic                                i_term_last,
    output logic                                     o_valid,
    output logic             [srdp_pkg::ROW_W-1:0]   o_row_number,
    output logic signed      [srdp_pkg::SUM_W-1:0]   o_row_value
);

    import srdp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_row, n_row, row_inc;
    logic signed [VALUE_W-1:0] r_coef;
    logic                     r_negate, r_last, r_in_range;
    logic                     r_valid, n_valid;
    logic [ROW_W-1:0]         r_row_number, n_row_number;
    logic signed [SUM_W-1:0]  r_row_value, n_row_value;

    logic                     accept, in_range;
    logic [VALUE_W-1:0]       rdata;
    logic signed [VALUE_W-1:0] entry;
    logic signed [SUM_W-1:0]  sum_next;
    t_mac_ctrl                mac_ctrl;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign in_range = ({{(32-INDEX_W){1'b0}}, i_index} < 32'(VECTOR_DEPTH));
    assign row_inc  = (r_row == CNT_W'(MAX_ROWS - 1)) ? '0 : r_row + 1'b1;

    // Vector store: loads write, terms read
    srdp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && i_mode == MODE_LOAD && in_range),
        .i_addr  (ADDR_W'(i_index)),
        .i_wdata (i_value),
        .o_rdata (rdata)
    );

    // Out-of-range reads count as zero
    assign entry = r_in_range ? $signed(rdata) : '0;

    srdp_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (mac_ctrl),
        .i_coef     (r_coef),
        .i_entry    (entry),
        .o_sum_next (sum_next)
    );

    // Sequence items and form results
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_valid      = 1'b0;
        n_row_number = row_out(r_row);
        n_row_value  = '0;
        mac_ctrl     = '{mul_en: 1'b0, acc_en: 1'b0, negate: r_negate, clear: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_TERM: begin
                            n_state = ST_READ;
                        end
                        MODE_EMPTY: begin
                            n_valid        = 1'b1;
                            mac_ctrl.clear = 1'b1;
                            n_row          = row_inc;
                        end
                        MODE_RESTART: begin
                            mac_ctrl.clear = 1'b1;
                            n_row          = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                mac_ctrl.mul_en = 1'b1;
                n_state         = ST_ACC;
            end
            ST_ACC: begin
                mac_ctrl.acc_en = 1'b1;
                n_state         = ST_IDLE;
                if (r_last) begin
                    n_valid        = 1'b1;
                    n_row_value    = sum_next;
                    mac_ctrl.clear = 1'b1;
                    n_row          = row_inc;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    // Hold the term's fields and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coef     <= i_value;
            r_negate   <= i_row_negate;
            r_last     <= i_term_last;
            r_in_range <= in_range;
        end
        r_row_number <= n_row_number;
        r_row_value  <= n_row_value;
    end

    assign o_valid      = r_valid;
    assign o_row_number = r_row_number;
    assign o_row_value  = r_row_value;

endmodule

`default_nettype wire

FILE: sv/srdp_ram.sv
// ----------------------------------------------------------------------------
// srdp_ram
// Generic single-port synchronous RAM, one read per cycle plus an optional
// write to the same address, registered read data (old contents on a write).
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

FILE: sv/srdp_mac.sv
// ----------------------------------------------------------------------------
// srdp_mac
// Multiply-accumulate datapath: registered Q32.32 product, floor to Q32.16,
// add or subtract into the saturating row sum.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire srdp_pkg::t_mac_ctrl                 i_ctrl,
    input  wire logic signed [srdp_pkg::VALUE_W-1:0] i_coef,
    input  wire logic signed [srdp_pkg::VALUE_W-1:0] i_entry,
    output logic signed      [srdp_pkg::SUM_W-1:0]   o_sum_next
);

    import srdp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  prod_q;
    logic signed [EXT_W-1:0]  ext;

    // Capture the full product
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_entry;
        end
    end

    // Floor to Q32.16 by dropping fraction bits, then add or subtract
    assign prod_q = r_prod[PROD_W-1:FRAC_W];

    always_comb begin
        if (i_ctrl.negate) begin
            ext = {{2{r_sum[SUM_W-1]}}, r_sum} - {{2{prod_q[SUM_W-1]}}, prod_q};
        end else begin
            ext = {{2{r_sum[SUM_W-1]}}, r_sum} + {{2{prod_q[SUM_W-1]}}, prod_q};
        end
        // Clamp to the 48-bit range
        if (ext[EXT_W-1:SUM_W-1] == '0 || ext[EXT_W-1:SUM_W-1] == '1) begin
            o_sum_next = ext[SUM_W-1:0];
        end else if (ext[EXT_W-1]) begin
            o_sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            o_sum_next = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // Hold the running row sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.acc_en) begin
            r_sum <= o_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/srdp_checker.sv
// ----------------------------------------------------------------------------
// srdp_checker
// Port-level checks on the sparse row dot product block.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic        [srdp_pkg::MODE_W-1:0]  i_mode,
    input  wire logic                                i_term_last,
    input  wire logic                                o_valid,
    input  wire logic signed [srdp_pkg::SUM_W-1:0]   o_row_value
);

    import srdp_pkg::*;

    logic xfer;
    assign xfer = start && !busy;

    // Reset leaves no strobe and no work in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("strobe or busy after reset");

    // An empty row gives a zero result on the next cycle
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_mode == MODE_EMPTY |=> o_valid && o_row_value == '0)
        else $error("empty row did not give zero");

    // Loads and restarts give no result
    a_quiet_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && (i_mode == MODE_LOAD || i_mode == MODE_RESTART) |=> !o_valid)
        else $error("result after load or restart");

    // A last term gives a row result strobe
    a_last_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_mode == MODE_TERM && i_term_last |-> ##3 o_valid)
        else $error("missing row result");

    // A term that is not last gives nothing
    a_mid_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_mode == MODE_TERM && !i_term_last |-> ##3 !o_valid)
        else $error("result from a term not marked last");

endmodule

bind sparse_row_dot_product srdp_checker u_srdp_checker (.*);

`default_nettype wire
